>>> hdl/usm_pkg.sv
// Shared types and constants for the 3x3 unsharp mask block.
`default_nettype none
package usm_pkg;
	localparam int PIX_W = 8;
	localparam int FW_W = 11;
	localparam int FH_W = 13;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam logic [FW_W-1:0] FW_RST = 11'd640;
	localparam logic [FH_W-1:0] FH_RST = 13'd480;

	// register index, taken from paddr[2]
	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	// neighborhood sizes and the reciprocals of 2*n, scaled by 2^RECIP_SHIFT
	localparam int SUM_W = 12;
	localparam int NUM_W = 15;
	localparam int N_W = 4;
	localparam int RECIP_W = 16;
	localparam int RECIP_SHIFT = 18;
	localparam logic [N_W-1:0] N_CORNER = 4'd4;
	localparam logic [N_W-1:0] N_EDGE = 4'd6;
	localparam logic [N_W-1:0] N_INNER = 4'd9;
	localparam logic [RECIP_W-1:0] RECIP_CORNER = 16'd32768;
	localparam logic [RECIP_W-1:0] RECIP_EDGE = 16'd21846;
	localparam logic [RECIP_W-1:0] RECIP_INNER = 16'd14564;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// 3x3 window, element r*3+c, column 2 is the newest
	typedef logic [8:0][PIX_W-1:0] usm_win_t;

	// which sides of the window lie inside the frame, plus end of frame
	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} usm_edge_t;
endpackage
`default_nettype wire

>>> hdl/usm_sharpen.sv
// Sharpening arithmetic: masked window sum, numerator, scaled divide and clamp.
`default_nettype none
module usm_sharpen (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              win_valid,
	input  wire usm_pkg::usm_win_t  win,
	input  wire usm_pkg::usm_edge_t edges,
	output logic                   win_take,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [usm_pkg::PIX_W-1:0] pixel_out,
	output logic                   frame_end
);
	localparam int PROD_W = usm_pkg::NUM_W - 1 + usm_pkg::RECIP_W;

	logic                          v2_q, v3_q, vo_q;
	logic [usm_pkg::SUM_W-1:0]     sum_s2;
	logic [usm_pkg::PIX_W-1:0]     p_s2;
	logic [usm_pkg::N_W-1:0]       n_s2;
	logic                          last_s2;
	logic signed [usm_pkg::NUM_W-1:0] num_s3;
	logic [usm_pkg::RECIP_W-1:0]   recip_s3;
	logic                          last_s3;
	logic [usm_pkg::PIX_W-1:0]     pix_q;
	logic                          fend_q;

	logic                          rdy3, rdy2;
	logic [usm_pkg::SUM_W-1:0]     sum_c;
	logic [usm_pkg::N_W-1:0]       n_c;
	logic [2:0]                    row_ok, col_ok;
	logic [usm_pkg::SUM_W-1:0]     pn_c;
	logic [usm_pkg::NUM_W-1:0]     pos_c, neg_c;
	logic signed [usm_pkg::NUM_W-1:0] num_c;
	logic [usm_pkg::RECIP_W-1:0]   recip_c;
	logic [PROD_W-1:0]             prod_c;
	logic [usm_pkg::SUM_W-1:0]     quot_c;
	logic [usm_pkg::PIX_W-1:0]     res_c;

	assign rdy3 = !v3_q || !vo_q || !out_stall;
	assign rdy2 = !v2_q || rdy3;
	assign win_take = rdy2;

	// stage 1 -> 2: sum of in-frame neighbors and their count
	always_comb begin
		row_ok = {edges.bot_ok, 1'b1, edges.top_ok};
		col_ok = {edges.right_ok, 1'b1, edges.left_ok};
		sum_c = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (row_ok[r] && col_ok[c]) begin
					sum_c = sum_c + usm_pkg::SUM_W'(win[r*3+c]);
				end
			end
		end
		if (edges.top_ok && edges.bot_ok && edges.left_ok && edges.right_ok) begin
			n_c = usm_pkg::N_INNER;
		end else if ((edges.top_ok && edges.bot_ok) || (edges.left_ok && edges.right_ok)) begin
			n_c = usm_pkg::N_EDGE;
		end else begin
			n_c = usm_pkg::N_CORNER;
		end
	end

	// stage 2 -> 3: num = 4*p*n + n - 2*sum, floor(num / 2n) is the rounded result
	always_comb begin
		pn_c = usm_pkg::SUM_W'(p_s2) * usm_pkg::SUM_W'(n_s2);
		pos_c = {1'b0, pn_c, 2'b00} + usm_pkg::NUM_W'(n_s2);
		neg_c = usm_pkg::NUM_W'({sum_s2, 1'b0});
		num_c = $signed(pos_c - neg_c);
		case (n_s2)
			usm_pkg::N_INNER: recip_c = usm_pkg::RECIP_INNER;
			usm_pkg::N_EDGE:  recip_c = usm_pkg::RECIP_EDGE;
			default:          recip_c = usm_pkg::RECIP_CORNER;
		endcase
	end

	// stage 3 -> out: reciprocal multiply is exact for num below 2^14
	always_comb begin
		prod_c = PROD_W'(num_s3[usm_pkg::NUM_W-2:0]) * PROD_W'(recip_s3);
		quot_c = usm_pkg::SUM_W'(prod_c >> usm_pkg::RECIP_SHIFT);
		if (num_s3[usm_pkg::NUM_W-1]) begin
			res_c = '0;
		end else if (quot_c > usm_pkg::SUM_W'(usm_pkg::PIX_MAX)) begin
			res_c = usm_pkg::PIX_MAX;
		end else begin
			res_c = quot_c[usm_pkg::PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy2) begin
				v2_q <= win_valid;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
			if (!vo_q || !out_stall) begin
				vo_q <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && win_valid) begin
			sum_s2 <= sum_c;
			p_s2 <= win[4];
			n_s2 <= n_c;
			last_s2 <= edges.last;
		end
		if (rdy3 && v2_q) begin
			num_s3 <= num_c;
			recip_s3 <= recip_c;
			last_s3 <= last_s2;
		end
		if ((!vo_q || !out_stall) && v3_q) begin
			pix_q <= res_c;
			fend_q <= last_s3;
		end
	end

	assign out_valid = vo_q;
	assign pixel_out = pix_q;
	assign frame_end = fend_q;
endmodule
`default_nettype wire

>>> hdl/unsharp_mask_3x3.sv
// Top level: 3x3 unsharp mask over a raster pixel stream with two line stores.
//
//   channel | direction | handshake           | word
//   in      | input     | in_valid / in_stall | func, pixel_in
//   out     | output    | out_valid/out_stall | pixel_out, frame_end
//   cfg     | input     | APB psel/penable    | frame_width @0, frame_height @4
//
// One word is taken every clock while in_stall is low; each line store does one read per cycle and
// at most one write, with the read address set up ahead from the next column.
// A result passes the window, stage 2, stage 3 and output registers once its window is complete;
// results trail the input by frame_width+1 words, flush words drain the rest.
// Reset clears counters, window and valid bits; line store contents start undefined.
// A stalled output fills the three arithmetic stages before in_stall rises.
`default_nettype none
module unsharp_mask_3x3 #(
	parameter int MAX_WIDTH = usm_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = usm_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       func,
	input  wire logic [usm_pkg::PIX_W-1:0]  pixel_in,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [usm_pkg::PIX_W-1:0]       pixel_out,
	output logic                            frame_end,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [usm_pkg::APB_AW-1:0] paddr,
	input  wire logic [usm_pkg::APB_DW-1:0] pwdata,
	output logic [usm_pkg::APB_DW-1:0]      prdata,
	output logic                            pready
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WCW = $clog2(MAX_WIDTH + 1);
	localparam int HCW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int ORW = $clog2(MAX_HEIGHT);

	logic [usm_pkg::FW_W-1:0]  fw_q;
	logic [usm_pkg::FH_W-1:0]  fh_q;
	logic [WCW-1:0]            w_eff;
	logic [HCW-1:0]            h_eff;
	logic                      cfg_we;

	logic [CW-1:0]  in_col_q, in_col_d;
	logic [RW-1:0]  in_row_q, in_row_d;
	logic [CW-1:0]  out_col_q, out_col_d;
	logic [ORW-1:0] out_row_q, out_row_d;

	logic [usm_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [usm_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [usm_pkg::PIX_W-1:0] top_rd_q, mid_rd_q;

	usm_pkg::usm_win_t  win_s1;
	usm_pkg::usm_edge_t edges_s1, edges_c;
	logic               v1_q;
	logic               win_take;

	logic                      in_accept, draining, do_step, emit, last;
	logic [usm_pkg::PIX_W-1:0] pix;
	logic [WCW-1:0]            ic_inc, oc_inc;
	logic [HCW-1:0]            or_inc;
	logic                      ic_wrap, oc_wrap, row_last;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[2])
			usm_pkg::REG_FRAME_WIDTH:  prdata = usm_pkg::APB_DW'(fw_q);
			usm_pkg::REG_FRAME_HEIGHT: prdata = usm_pkg::APB_DW'(fh_q);
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= usm_pkg::FW_RST;
			fh_q <= usm_pkg::FH_RST;
		end else if (cfg_we) begin
			unique case (paddr[2])
				usm_pkg::REG_FRAME_WIDTH:  fw_q <= pwdata[usm_pkg::FW_W-1:0];
				usm_pkg::REG_FRAME_HEIGHT: fh_q <= pwdata[usm_pkg::FH_W-1:0];
				default: ;
			endcase
		end
	end

	// registers used clamped to 2..MAX
	always_comb begin
		if (32'(fw_q) > 32'(MAX_WIDTH)) begin
			w_eff = WCW'(MAX_WIDTH);
		end else if (fw_q < usm_pkg::FW_W'(2)) begin
			w_eff = WCW'(2);
		end else begin
			w_eff = WCW'(fw_q);
		end
		if (32'(fh_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HCW'(MAX_HEIGHT);
		end else if (fh_q < usm_pkg::FH_W'(2)) begin
			h_eff = HCW'(2);
		end else begin
			h_eff = HCW'(fh_q);
		end
	end

	// input side
	assign in_stall = v1_q && !win_take;
	assign in_accept = in_valid && !in_stall;
	assign draining = 32'(in_row_q) >= 32'(h_eff);
	// a flush word before the end of the frame does nothing; a pixel while draining flushes
	assign do_step = in_accept && (func == usm_pkg::FUNC_PIXEL || draining);
	assign pix = draining ? '0 : pixel_in;

	assign ic_inc = WCW'(in_col_q) + WCW'(1);
	assign ic_wrap = ic_inc >= w_eff;
	assign oc_inc = WCW'(out_col_q) + WCW'(1);
	assign oc_wrap = oc_inc >= w_eff;
	assign or_inc = HCW'(out_row_q) + HCW'(1);
	assign row_last = or_inc >= h_eff;

	// first result comes with the second pixel of row 1
	assign emit = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
	assign last = emit && oc_wrap && row_last;

	always_comb begin
		edges_c.top_ok = out_row_q != '0;
		edges_c.bot_ok = !row_last;
		edges_c.left_ok = out_col_q != '0;
		edges_c.right_ok = !oc_wrap;
		edges_c.last = last;
	end

	always_comb begin
		in_col_d = in_col_q;
		in_row_d = in_row_q;
		out_col_d = out_col_q;
		out_row_d = out_row_q;
		if (cfg_we || (do_step && last)) begin
			in_col_d = '0;
			in_row_d = '0;
			out_col_d = '0;
			out_row_d = '0;
		end else if (do_step) begin
			if (ic_wrap) begin
				in_col_d = '0;
				in_row_d = in_row_q + RW'(1);
			end else begin
				in_col_d = ic_inc[CW-1:0];
			end
			if (emit) begin
				if (oc_wrap) begin
					out_col_d = '0;
					out_row_d = out_row_q + ORW'(1);
				end else begin
					out_col_d = oc_inc[CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			in_col_q <= in_col_d;
			in_row_q <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
		end
	end

	// line stores: read ahead at the next column, which differs from the column written except on a frame restart
	always_ff @(posedge clk) begin
		if (do_step) begin
			upper_mem[in_col_q] <= mid_rd_q;
			middle_mem[in_col_q] <= pix;
		end
		top_rd_q <= upper_mem[in_col_d];
		mid_rd_q <= middle_mem[in_col_d];
	end

	// window shifts left, new column enters at the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_s1 <= '0;
			v1_q <= 1'b0;
		end else begin
			if (do_step) begin
				for (int r = 0; r < 3; r++) begin
					win_s1[r*3] <= win_s1[r*3+1];
					win_s1[r*3+1] <= win_s1[r*3+2];
				end
				win_s1[2] <= top_rd_q;
				win_s1[5] <= mid_rd_q;
				win_s1[8] <= pix;
				v1_q <= emit;
			end else if (win_take) begin
				v1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			edges_s1 <= edges_c;
		end
	end

	usm_sharpen u_sharpen (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (v1_q),
		.win       (win_s1),
		.edges     (edges_s1),
		.win_take  (win_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.frame_end (frame_end)
	);

	// counters stay inside the configured frame; the input row may run two rows past it while draining
	a_in_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(in_col_q) < 32'(w_eff))
		else $error("input column beyond frame width");

	a_out_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(out_row_q) < 32'(h_eff)) && (32'(in_row_q) <= 32'(h_eff) + 32'd1))
		else $error("row counter beyond frame height");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0))
		else $error("register write did not restart the frame");
endmodule
`default_nettype wire
